FILE: hdl/exl_pkg.sv
// ----------------------------------------------------------------------------
// Expression lexer package
// Shared types, character codes, token kinds and decode helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package exl_pkg;

    localparam int POSITION_BITS_DEFAULT = 16;

    // Result queue geometry.
    localparam int RESULT_DEPTH = 4;
    localparam int PTR_BITS     = 2;
    localparam int CNT_BITS     = 3;

    // Character codes.
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_EQUALS = 8'h3D;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_DIGIT_0 = 8'h30;
    localparam logic [7:0] CH_DIGIT_9 = 8'h39;

    // Token kinds.
    localparam logic [3:0] KIND_IDENT   = 4'd0;
    localparam logic [3:0] KIND_LITERAL = 4'd1;
    localparam logic [3:0] KIND_LPAREN  = 4'd2;
    localparam logic [3:0] KIND_RPAREN  = 4'd3;
    localparam logic [3:0] KIND_LBRACK  = 4'd4;
    localparam logic [3:0] KIND_RBRACK  = 4'd5;
    localparam logic [3:0] KIND_LBRACE  = 4'd6;
    localparam logic [3:0] KIND_RBRACE  = 4'd7;
    localparam logic [3:0] KIND_PLUS    = 4'd8;
    localparam logic [3:0] KIND_MINUS   = 4'd9;
    localparam logic [3:0] KIND_STAR    = 4'd10;
    localparam logic [3:0] KIND_SLASH   = 4'd11;
    localparam logic [3:0] KIND_CARET   = 4'd12;
    localparam logic [3:0] KIND_COMMA   = 4'd13;
    localparam logic [3:0] KIND_ASSIGN  = 4'd14;

    // Error codes.
    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_DOTS    = 2'd1;
    localparam logic [1:0] ERR_NOMATCH = 2'd2;
    localparam logic [1:0] ERR_EQUALS  = 2'd3;

    localparam logic [15:0] LENGTH_MAX = 16'hFFFF;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_IDENT,
        MODE_LITERAL,
        MODE_COLON,
        MODE_DROP
    } scan_mode_t;

    typedef struct packed {
        logic [3:0]  token_kind;
        logic [15:0] token_start;
        logic [15:0] token_length;
        logic [1:0]  error_code;
        logic        end_of_run;
    } token_t;

    // Up to two results per character; a comes before b.
    typedef struct packed {
        logic   a_valid;
        token_t a;
        logic   b_valid;
        token_t b;
    } scan_out_t;

    typedef struct packed {
        logic       hit;
        logic [3:0] kind;
    } single_t;

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) ||
               ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_DIGIT_0) && (c <= CH_DIGIT_9);
    endfunction

    function automatic single_t single_kind(input logic [7:0] c);
        single_t s;
        s.hit  = 1'b1;
        s.kind = KIND_IDENT;
        case (c)
            CH_LPAREN: s.kind = KIND_LPAREN;
            CH_RPAREN: s.kind = KIND_RPAREN;
            CH_LBRACK: s.kind = KIND_LBRACK;
            CH_RBRACK: s.kind = KIND_RBRACK;
            CH_LBRACE: s.kind = KIND_LBRACE;
            CH_RBRACE: s.kind = KIND_RBRACE;
            CH_PLUS:   s.kind = KIND_PLUS;
            CH_MINUS:  s.kind = KIND_MINUS;
            CH_STAR:   s.kind = KIND_STAR;
            CH_SLASH:  s.kind = KIND_SLASH;
            CH_CARET:  s.kind = KIND_CARET;
            CH_COMMA:  s.kind = KIND_COMMA;
            default:   s.hit  = 1'b0;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/exl_char_if.sv
// ----------------------------------------------------------------------------
// Character channel
// Valid/ready channel carrying one character of the expression string.
// ----------------------------------------------------------------------------
`default_nettype none

interface exl_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

`default_nettype wire

FILE: hdl/exl_token_if.sv
// ----------------------------------------------------------------------------
// Token channel
// Valid/ready channel carrying one token or error report.
// ----------------------------------------------------------------------------
`default_nettype none

interface exl_token_if;
    logic        valid;
    logic        ready;
    logic [3:0]  token_kind;
    logic [15:0] token_start;
    logic [15:0] token_length;
    logic [1:0]  error_code;
    logic        end_of_run;

    modport source (output valid, output token_kind, output token_start,
                    output token_length, output error_code, output end_of_run,
                    input ready);
    modport sink   (input valid, input token_kind, input token_start,
                    input token_length, input error_code, input end_of_run,
                    output ready);
endinterface

`default_nettype wire

FILE: hdl/exl_scan.sv
// ----------------------------------------------------------------------------
// Lexer scan stage
// Holds the scanner state and decides, per accepted character, the tokens
// that it completes (at most two) and the next state.
// ----------------------------------------------------------------------------
`default_nettype none

module exl_scan #(
    parameter int POSITION_BITS = exl_pkg::POSITION_BITS_DEFAULT
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               accept,
    input  wire logic [7:0]         char_code,
    input  wire logic               last_char,
    input  wire logic               cfg_wr_en,
    input  wire logic [15:0]        cfg_wr_data,
    output exl_pkg::scan_out_t      results
);

    localparam int SW = (POSITION_BITS > 16) ? POSITION_BITS : 16;
    localparam logic [SW-1:0] PMASK = SW'((64'd1 << POSITION_BITS) - 64'd1);

    exl_pkg::scan_mode_t        mode_reg, mode_next;
    logic [POSITION_BITS-1:0]   pos_reg, pos_next;
    logic [POSITION_BITS-1:0]   pstart_reg, pstart_next;
    logic [15:0]                plen_reg, plen_next;
    logic [1:0]                 dots_reg, dots_next;
    logic [15:0]                base_reg;

    // Decode of a character that begins a new token.
    exl_pkg::scan_mode_t        sc_mode;
    logic                       sc_load;
    logic                       sc_emit;
    logic [3:0]                 sc_kind;
    logic [15:0]                sc_len;
    logic [1:0]                 sc_err;
    exl_pkg::single_t           sk;

    logic                       a_v, b_v;
    logic [3:0]                 a_kind, b_kind;
    logic [POSITION_BITS-1:0]   a_off, b_off;
    logic [15:0]                a_len, b_len;
    logic [1:0]                 a_err, b_err;
    logic                       start_now;
    logic [15:0]                plen_inc;

    function automatic logic [15:0] abs_pos(input logic [POSITION_BITS-1:0] off);
        logic [SW-1:0] s;
        s = (SW'(base_reg) + SW'(off)) & PMASK;
        return s[15:0];
    endfunction

    always_comb
    begin
        sk      = exl_pkg::single_kind(char_code);
        sc_mode = exl_pkg::MODE_DROP;
        sc_load = 1'b0;
        sc_emit = 1'b0;
        sc_kind = exl_pkg::KIND_IDENT;
        sc_len  = 16'd1;
        sc_err  = exl_pkg::ERR_NONE;
        if (char_code == exl_pkg::CH_SPACE)
        begin
            sc_mode = exl_pkg::MODE_IDLE;
        end
        else if (exl_pkg::is_letter(char_code))
        begin
            sc_mode = exl_pkg::MODE_IDENT;
            sc_load = 1'b1;
        end
        else if (exl_pkg::is_digit(char_code))
        begin
            sc_mode = exl_pkg::MODE_LITERAL;
            sc_load = 1'b1;
        end
        else if (sk.hit)
        begin
            sc_mode = exl_pkg::MODE_IDLE;
            sc_emit = 1'b1;
            sc_kind = sk.kind;
        end
        else if (char_code == exl_pkg::CH_COLON)
        begin
            sc_mode = exl_pkg::MODE_COLON;
            sc_load = 1'b1;
        end
        else if (char_code == exl_pkg::CH_EQUALS)
        begin
            sc_emit = 1'b1;
            sc_len  = 16'd0;
            sc_err  = exl_pkg::ERR_EQUALS;
        end
        else
        begin
            sc_emit = 1'b1;
            sc_err  = exl_pkg::ERR_NOMATCH;
        end
    end

    assign plen_inc = (plen_reg == exl_pkg::LENGTH_MAX) ? plen_reg : plen_reg + 16'd1;

    always_comb
    begin
        mode_next   = mode_reg;
        pstart_next = pstart_reg;
        plen_next   = plen_reg;
        dots_next   = dots_reg;
        pos_next    = pos_reg + POSITION_BITS'(1);
        start_now   = 1'b0;
        a_v    = 1'b0;
        a_kind = exl_pkg::KIND_IDENT;
        a_off  = pstart_reg;
        a_len  = plen_reg;
        a_err  = exl_pkg::ERR_NONE;
        b_v    = 1'b0;
        b_kind = exl_pkg::KIND_IDENT;
        b_off  = pos_reg;
        b_len  = 16'd1;
        b_err  = exl_pkg::ERR_NONE;

        // First result: the pending token that this character closes.
        case (mode_reg)
            exl_pkg::MODE_IDENT:
            begin
                if (exl_pkg::is_letter(char_code))
                begin
                    plen_next = plen_inc;
                end
                else
                begin
                    a_v       = 1'b1;
                    start_now = 1'b1;
                end
            end
            exl_pkg::MODE_LITERAL:
            begin
                if (exl_pkg::is_digit(char_code) || (char_code == exl_pkg::CH_DOT))
                begin
                    plen_next = plen_inc;
                    if ((char_code == exl_pkg::CH_DOT) && (dots_reg != 2'd2))
                    begin
                        dots_next = dots_reg + 2'd1;
                    end
                end
                else if (dots_reg == 2'd2)
                begin
                    a_v       = 1'b1;
                    a_err     = exl_pkg::ERR_DOTS;
                    mode_next = exl_pkg::MODE_DROP;
                end
                else
                begin
                    a_v       = 1'b1;
                    a_kind    = exl_pkg::KIND_LITERAL;
                    start_now = 1'b1;
                end
            end
            exl_pkg::MODE_COLON:
            begin
                a_v = 1'b1;
                if (char_code == exl_pkg::CH_EQUALS)
                begin
                    a_kind    = exl_pkg::KIND_ASSIGN;
                    a_len     = 16'd2;
                    mode_next = exl_pkg::MODE_IDLE;
                end
                else
                begin
                    a_len     = 16'd1;
                    a_err     = exl_pkg::ERR_NOMATCH;
                    mode_next = exl_pkg::MODE_DROP;
                end
            end
            exl_pkg::MODE_DROP:
            begin
                mode_next = exl_pkg::MODE_DROP;
            end
            default:
            begin
                start_now = 1'b1;
            end
        endcase

        // Second result: a one-character token or error from the new character.
        if (start_now)
        begin
            mode_next = sc_mode;
            b_v       = sc_emit;
            b_kind    = sc_kind;
            b_len     = sc_len;
            b_err     = sc_err;
            if (sc_load)
            begin
                pstart_next = pos_reg;
                plen_next   = 16'd1;
                dots_next   = 2'd0;
            end
        end

        // The last character flushes whatever is still pending. This cannot
        // coincide with a one-character result, so it reuses the second slot.
        if (last_char)
        begin
            b_off = pstart_next;
            case (mode_next)
                exl_pkg::MODE_IDENT:
                begin
                    b_v    = 1'b1;
                    b_kind = exl_pkg::KIND_IDENT;
                    b_len  = plen_next;
                    b_err  = exl_pkg::ERR_NONE;
                end
                exl_pkg::MODE_LITERAL:
                begin
                    b_v    = 1'b1;
                    b_len  = plen_next;
                    if (dots_next == 2'd2)
                    begin
                        b_kind = exl_pkg::KIND_IDENT;
                        b_err  = exl_pkg::ERR_DOTS;
                    end
                    else
                    begin
                        b_kind = exl_pkg::KIND_LITERAL;
                        b_err  = exl_pkg::ERR_NONE;
                    end
                end
                exl_pkg::MODE_COLON:
                begin
                    b_v    = 1'b1;
                    b_kind = exl_pkg::KIND_IDENT;
                    b_len  = 16'd1;
                    b_err  = exl_pkg::ERR_NOMATCH;
                end
                default:
                begin
                    b_off = pos_reg;
                end
            endcase
            mode_next   = exl_pkg::MODE_IDLE;
            pos_next    = '0;
            pstart_next = '0;
            plen_next   = 16'd0;
            dots_next   = 2'd0;
        end
    end

    always_comb
    begin
        results.a_valid        = accept && a_v;
        results.a.token_kind   = a_kind;
        results.a.token_start  = abs_pos(a_off);
        results.a.token_length = a_len;
        results.a.error_code   = a_err;
        results.a.end_of_run   = !b_v;
        results.b_valid        = accept && b_v;
        results.b.token_kind   = b_kind;
        results.b.token_start  = abs_pos(b_off);
        results.b.token_length = b_len;
        results.b.error_code   = b_err;
        results.b.end_of_run   = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= exl_pkg::MODE_IDLE;
            pos_reg    <= '0;
            pstart_reg <= '0;
            plen_reg   <= 16'd0;
            dots_reg   <= 2'd0;
            base_reg   <= 16'd0;
        end
        else
        begin
            if (accept)
            begin
                mode_reg   <= mode_next;
                pos_reg    <= pos_next;
                pstart_reg <= pstart_next;
                plen_reg   <= plen_next;
                dots_reg   <= dots_next;
            end
            if (cfg_wr_en)
            begin
                base_reg <= cfg_wr_data;
            end
        end
    end

endmodule

`default_nettype wire

FILE: hdl/exl_result_fifo.sv
// ----------------------------------------------------------------------------
// Lexer result queue
// Small queue that takes up to two results per cycle and hands out one.
// ----------------------------------------------------------------------------
`default_nettype none

module exl_result_fifo (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire exl_pkg::scan_out_t push,
    input  wire logic               pop_ready,
    output logic                    head_valid,
    output exl_pkg::token_t         head,
    output logic                    space_ok
);

    exl_pkg::token_t                entries [exl_pkg::RESULT_DEPTH];
    logic [exl_pkg::PTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [exl_pkg::PTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [exl_pkg::CNT_BITS-1:0]   count_reg, count_next;
    logic [exl_pkg::PTR_BITS-1:0]   wr_ptr_inc;
    logic                           first_v, second_v, pop;
    logic [1:0]                     n_push;
    exl_pkg::token_t                first;

    assign first_v    = push.a_valid || push.b_valid;
    assign second_v   = push.a_valid && push.b_valid;
    assign first      = push.a_valid ? push.a : push.b;
    assign n_push     = {1'b0, push.a_valid} + {1'b0, push.b_valid};
    assign wr_ptr_inc = wr_ptr_reg + exl_pkg::PTR_BITS'(1);

    assign head_valid = (count_reg != '0);
    assign head       = entries[rd_ptr_reg];
    assign pop        = head_valid && pop_ready;
    // Room for the two results that one character may cause.
    assign space_ok   = (count_reg <= exl_pkg::CNT_BITS'(exl_pkg::RESULT_DEPTH - 2));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + exl_pkg::PTR_BITS'(n_push);
        rd_ptr_next = pop ? rd_ptr_reg + exl_pkg::PTR_BITS'(1) : rd_ptr_reg;
        count_next  = count_reg + exl_pkg::CNT_BITS'(n_push)
                      - exl_pkg::CNT_BITS'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (first_v)
        begin
            entries[wr_ptr_reg] <= first;
        end
        if (second_v)
        begin
            entries[wr_ptr_inc] <= push.b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/expression_lexer_unit.sv
// ----------------------------------------------------------------------------
// Expression lexer
// Streaming tokenizer: characters in, (kind, start, length, error) tokens out.
// ----------------------------------------------------------------------------
// Characters arrive on the chars channel, one per transaction, with last_char
// marking the end of a string. Tokens leave on the tokens channel; end_of_run
// flags the last token caused by a given character. A character causes zero,
// one or two tokens.
// The base position register is written through cfg_wr_en/cfg_wr_data; the
// user must write it only while no string is in flight, as the block does
// not enforce this. Token positions are that base plus the offset. A
// character is decoded in the cycle it is accepted and its tokens are written
// to a four-entry result queue, so a token is in the queue from the cycle
// after its character is accepted. One character is accepted per cycle as
// long as the queue holds at most two tokens; two tokens from one character
// leave one at a time through the single output port. A receiver stall
// fills the queue and drops chars.ready; nothing is lost. Reset empties the
// queue, clears the scanner to idle at offset zero, clears the base position.
// ----------------------------------------------------------------------------
`default_nettype none

module expression_lexer_unit #(
    parameter int POSITION_BITS = exl_pkg::POSITION_BITS_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    exl_char_if.sink         chars,
    exl_token_if.source      tokens,
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data
);

    exl_pkg::scan_out_t scan_results;
    exl_pkg::token_t    head;
    logic               space_ok;
    logic               accept;

    assign chars.ready = space_ok;
    assign accept      = chars.valid && space_ok;

    exl_scan #(
        .POSITION_BITS (POSITION_BITS)
    ) u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .char_code   (chars.char_code),
        .last_char   (chars.last_char),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .results     (scan_results)
    );

    exl_result_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (scan_results),
        .pop_ready  (tokens.ready),
        .head_valid (tokens.valid),
        .head       (head),
        .space_ok   (space_ok)
    );

    assign tokens.token_kind   = head.token_kind;
    assign tokens.token_start  = head.token_start;
    assign tokens.token_length = head.token_length;
    assign tokens.error_code   = head.error_code;
    assign tokens.end_of_run   = head.end_of_run;

endmodule

`default_nettype wire
